// ----- rtl/core/shmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_pkg
// Shared types and constants of the shadow memory access checker.
// ----------------------------------------------------------------------------
package shmc_pkg;

  localparam int ADDR_BITS      = 48;
  localparam int LEN_BITS       = 17;
  localparam int TAG_BITS       = 8;
  localparam int MAX_SIZE       = 65536;
  localparam int GRANULE_SHIFT  = 3;
  localparam int SHADOW_ENTRIES = 4096;
  localparam int APB_ADDR_BITS  = 5;
  localparam int APB_DATA_BITS  = 64;

  localparam logic [1:0] MODE_CHECK    = 2'd0;
  localparam logic [1:0] MODE_POISON   = 2'd1;
  localparam logic [1:0] MODE_UNPOISON = 2'd2;

  localparam logic [1:0] REG_WINDOW_LOW   = 2'd0;
  localparam logic [1:0] REG_WINDOW_HIGH  = 2'd1;
  localparam logic [1:0] REG_CHECK_ENABLE = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_BITS-1:0]  length;
    logic [TAG_BITS-1:0]  tag;
    logic                 is_store;
  } req_t;

  typedef struct packed {
    logic                 violation;
    logic                 outside_window;
    logic [ADDR_BITS-1:0] first_bad_address;
    logic [TAG_BITS-1:0]  shadow_tag;
    logic                 write_access;
  } res_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] window_low;
    logic [ADDR_BITS-1:0] window_high;
    logic                 check_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_PLAN,
    ST_FILL,
    ST_TAIL,
    ST_RD,
    ST_EV,
    ST_CLS_RD,
    ST_CLS_EV,
    ST_DONE
  } walk_state_t;

endpackage

// ----- rtl/core/shadow_memory_access_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_top
// Shadow byte store per granule with poison, unpoison and access checks.
//
//   channel   | signals                          | handshake
//   request   | start, busy, request (req_t)     | taken when start & !busy
//   result    | done, result (res_t)             | one-cycle strobe, no stall
//   config    | psel, penable, pwrite, paddr ... | APB, pready tied high
//
// A request passes setup states PREP1, PREP2, PREP3 and PLAN, then fills the
// granules and closes the fill (plus a tail write for an unpoison), or scans
// granules with a read and an evaluate each (plus a read and an evaluate to
// classify a partial granule); the shadow RAM's registered read port sets the scan
// pace. After reset it clears all SHADOW_ENTRIES store entries with busy high.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_top #(
  parameter int GRANULE_SHIFT  = shmc_pkg::GRANULE_SHIFT,
  parameter int SHADOW_ENTRIES = shmc_pkg::SHADOW_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  shmc_pkg::req_t                     request,
  output logic                               done,
  output shmc_pkg::res_t                     result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [shmc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [shmc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [shmc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int AW = $clog2(SHADOW_ENTRIES);

  shmc_pkg::cfg_t cfg;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  shmc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  shmc_ram #(.WIDTH(8), .DEPTH(SHADOW_ENTRIES)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  shmc_walk #(.GRANULE_SHIFT(GRANULE_SHIFT), .SHADOW_ENTRIES(SHADOW_ENTRIES)) u_walk (
    .clk, .rst, .cfg, .start, .request, .busy, .done, .result,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

endmodule

// ----- rtl/core/shmc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module shmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/shmc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_regs
// APB configuration registers: window bounds and check enable.
// ----------------------------------------------------------------------------
module shmc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [shmc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [shmc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [shmc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output shmc_pkg::cfg_t                      cfg
);

  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0) begin
      unique case (idx)
        shmc_pkg::REG_WINDOW_LOW:   cfg.window_low   <= pwdata[shmc_pkg::ADDR_BITS-1:0];
        shmc_pkg::REG_WINDOW_HIGH:  cfg.window_high  <= pwdata[shmc_pkg::ADDR_BITS-1:0];
        shmc_pkg::REG_CHECK_ENABLE: cfg.check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      shmc_pkg::REG_WINDOW_LOW:   prdata = 64'(cfg.window_low);
      shmc_pkg::REG_WINDOW_HIGH:  prdata = 64'(cfg.window_high);
      shmc_pkg::REG_CHECK_ENABLE: prdata = 64'(cfg.check_enable);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/shmc_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_walk
// Request sequencer: range setup, granule fill and check scan over the
// shadow RAM, plus the clearing pass after reset.
// ----------------------------------------------------------------------------
module shmc_walk #(
  parameter int GRANULE_SHIFT  = shmc_pkg::GRANULE_SHIFT,
  parameter int SHADOW_ENTRIES = shmc_pkg::SHADOW_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  shmc_pkg::cfg_t                    cfg,
  input  logic                              start,
  input  shmc_pkg::req_t                    request,
  output logic                              busy,
  output logic                              done,
  output shmc_pkg::res_t                    result,
  output logic                              ram_we,
  output logic [$clog2(SHADOW_ENTRIES)-1:0] ram_waddr,
  output logic [7:0]                        ram_wdata,
  output logic [$clog2(SHADOW_ENTRIES)-1:0] ram_raddr,
  input  logic [7:0]                        ram_rdata
);

  localparam int AB = shmc_pkg::ADDR_BITS;
  localparam int LB = shmc_pkg::LEN_BITS;
  localparam int AW = $clog2(SHADOW_ENTRIES);
  localparam int GW = AB + 1 - GRANULE_SHIFT;
  localparam logic [GW-1:0] ENT   = GW'(SHADOW_ENTRIES);
  localparam logic [AW-1:0] LAST  = AW'(SHADOW_ENTRIES - 1);
  localparam logic [8:0]    GSIZE = 9'(1 << GRANULE_SHIFT);

  shmc_pkg::walk_state_t state, state_next;

  shmc_pkg::req_t           rq, req_sat;
  shmc_pkg::res_t           plan_res;
  logic [AB:0]              end_raw, last, end_off, last_off, fill_off;
  logic [AB-1:0]            addr_off, hi_off;
  logic                     a_in, a_eq_hi, end_lt_hi, last_in;
  logic [GW-1:0]            g, gend, ge, tail_g, k;
  logic [GRANULE_SHIFT-1:0] off;
  logic                     oob;
  logic [AW-1:0]            clr;
  logic [7:0]               v;
  logic                     v_pass, tail_go;

  assign v       = oob ? 8'd0 : ram_rdata;
  assign v_pass  = (g == ge) &&
                   ($signed({{(8-GRANULE_SHIFT){1'b0}}, off}) < $signed(v));
  assign tail_go = rq.mode == shmc_pkg::MODE_UNPOISON &&
                   rq.length[GRANULE_SHIFT-1:0] != '0 && end_lt_hi;

  always_comb begin
    req_sat = request;
    if (request.length > LB'(shmc_pkg::MAX_SIZE)) req_sat.length = LB'(shmc_pkg::MAX_SIZE);
  end

  always_comb begin
    plan_res = '0;
    if (rq.mode == shmc_pkg::MODE_CHECK) begin
      plan_res.write_access = rq.is_store;
      if (rq.length != '0 && cfg.check_enable && a_eq_hi) begin
        plan_res.violation         = 1'b1;
        plan_res.outside_window    = 1'b1;
        plan_res.first_bad_address = rq.address;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      shmc_pkg::ST_CLEAR:  if (clr == LAST) state_next = shmc_pkg::ST_IDLE;
      shmc_pkg::ST_IDLE:   if (start) state_next = shmc_pkg::ST_PREP1;
      shmc_pkg::ST_PREP1:  state_next = shmc_pkg::ST_PREP2;
      shmc_pkg::ST_PREP2:  state_next = shmc_pkg::ST_PREP3;
      shmc_pkg::ST_PREP3:  state_next = shmc_pkg::ST_PLAN;
      shmc_pkg::ST_PLAN: begin
        state_next = shmc_pkg::ST_DONE;
        if (rq.mode == shmc_pkg::MODE_POISON || rq.mode == shmc_pkg::MODE_UNPOISON) begin
          if (a_in) state_next = shmc_pkg::ST_FILL;
        end else if (rq.mode == shmc_pkg::MODE_CHECK) begin
          if (rq.length != '0 && cfg.check_enable && !a_eq_hi && a_in && last_in)
            state_next = shmc_pkg::ST_RD;
        end
      end
      shmc_pkg::ST_FILL: begin
        if (g >= gend) state_next = tail_go ? shmc_pkg::ST_TAIL : shmc_pkg::ST_DONE;
      end
      shmc_pkg::ST_TAIL:   state_next = shmc_pkg::ST_DONE;
      shmc_pkg::ST_RD:     state_next = shmc_pkg::ST_EV;
      shmc_pkg::ST_EV: begin
        if (v != 8'd0) begin
          if (v_pass || {1'b0, v} >= GSIZE) state_next = shmc_pkg::ST_DONE;
          else state_next = shmc_pkg::ST_CLS_RD;
        end else if (g == ge) begin
          state_next = shmc_pkg::ST_DONE;
        end else begin
          state_next = shmc_pkg::ST_RD;
        end
      end
      shmc_pkg::ST_CLS_RD: state_next = shmc_pkg::ST_CLS_EV;
      shmc_pkg::ST_CLS_EV: state_next = shmc_pkg::ST_DONE;
      shmc_pkg::ST_DONE:   state_next = shmc_pkg::ST_IDLE;
      default:             state_next = shmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = state != shmc_pkg::ST_IDLE;
    done      = state == shmc_pkg::ST_DONE;
    ram_we    = 1'b0;
    ram_waddr = g[AW-1:0];
    ram_wdata = 8'd0;
    ram_raddr = g[AW-1:0];
    unique case (state)
      shmc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
      end
      shmc_pkg::ST_FILL: begin
        ram_we    = g < gend;
        ram_wdata = rq.mode == shmc_pkg::MODE_POISON ? rq.tag : 8'd0;
      end
      shmc_pkg::ST_TAIL: begin
        ram_we    = tail_g < ENT;
        ram_waddr = tail_g[AW-1:0];
        ram_wdata = 8'(rq.length[GRANULE_SHIFT-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shmc_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == shmc_pkg::ST_CLEAR) clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      shmc_pkg::ST_IDLE: begin
        rq <= req_sat;
      end
      shmc_pkg::ST_PREP1: begin
        end_raw  <= {1'b0, rq.address} + (AB+1)'(rq.length);
        a_in     <= rq.address >= cfg.window_low && rq.address < cfg.window_high;
        a_eq_hi  <= rq.address == cfg.window_high;
        addr_off <= rq.address - cfg.window_low;
        hi_off   <= cfg.window_high - cfg.window_low;
      end
      shmc_pkg::ST_PREP2: begin
        last      <= end_raw - 1'b1;
        end_off   <= end_raw - {1'b0, cfg.window_low};
        end_lt_hi <= end_raw < {1'b0, cfg.window_high};
      end
      shmc_pkg::ST_PREP3: begin
        last_in  <= last >= {1'b0, cfg.window_low} && last < {1'b0, cfg.window_high};
        last_off <= last - {1'b0, cfg.window_low};
        fill_off <= end_lt_hi ? end_off : {1'b0, hi_off};
      end
      shmc_pkg::ST_PLAN: begin
        g      <= GW'(addr_off >> GRANULE_SHIFT);
        k      <= '0;
        gend   <= GW'(fill_off >> GRANULE_SHIFT) > ENT ? ENT : GW'(fill_off >> GRANULE_SHIFT);
        ge     <= GW'(last_off >> GRANULE_SHIFT);
        tail_g <= GW'(end_off >> GRANULE_SHIFT);
        off    <= last_off[GRANULE_SHIFT-1:0];
        result <= plan_res;
      end
      shmc_pkg::ST_FILL: begin
        if (g < gend) g <= g + 1'b1;
      end
      shmc_pkg::ST_RD, shmc_pkg::ST_CLS_RD: begin
        oob <= g >= ENT;
      end
      shmc_pkg::ST_EV: begin
        if (v != 8'd0) begin
          if (!v_pass) begin
            result <= {1'b1, result.outside_window,
                       rq.address + AB'(k << GRANULE_SHIFT), v, result.write_access};
            g      <= g + 1'b1;
          end
        end else begin
          g <= g + 1'b1;
          k <= k + 1'b1;
        end
      end
      shmc_pkg::ST_CLS_EV: begin
        result.shadow_tag <= v;
      end
      default: ;
    endcase
  end

endmodule
